/* rtl/core/met_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the escape-time point evaluator.
// Depends on nothing; every module of the block imports it.

package met_pkg;

   localparam int POINT_W         = 32;
   localparam int LIMIT_W         = 12;
   localparam int PALETTE_INDEX_W = 8;
   localparam int PALETTE_MAX     = 255;
   localparam int REQ_DATA_W      = 64;
   localparam int RSP_DATA_W      = 24;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd150;

   // Result item, escaped flag in the lowest bit.
   typedef struct packed {
      logic [PALETTE_INDEX_W-1:0] palette_index;
      logic [LIMIT_W-1:0]         step_count;
      logic                       escaped;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

/* rtl/core/met_mul.sv */
`timescale 1ns / 1ps
// Shared fixed-point multiplier: floor(a*b / 2^FRAC_W) in sign-magnitude form,
// one 32-bit slice of the second operand per cycle. Uses met_pkg.

module met_mul #(
   parameter int VALUE_W = 34,
   parameter int MAG_W   = 31,
   parameter int FRAC_W  = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [VALUE_W-1:0] op_a,
   input  logic signed [VALUE_W-1:0] op_b,
   output logic                      done,
   output logic signed [VALUE_W-1:0] result
);
   import met_pkg::*;

   localparam int CHUNK_W    = 32;
   localparam int NUM_CHUNKS = (MAG_W + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
   localparam int ACC_W      = MAG_W + PAD_W;
   localparam int PROD_W     = MAG_W + CHUNK_W;
   localparam int CNT_W      = $clog2(NUM_CHUNKS + 1);

   typedef enum logic [1:0] {
      M_IDLE,
      M_ACCUM,
      M_ROUND
   } mul_state_type;

   mul_state_type              state_ff, state_in;
   logic [MAG_W-1:0]           a_mag_ff, a_mag_in;
   logic [PAD_W-1:0]           b_mag_ff, b_mag_in;
   logic                       neg_ff, neg_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic signed [VALUE_W-1:0]  result_ff, result_in;

   logic [VALUE_W-1:0]         abs_a;
   logic [VALUE_W-1:0]         abs_b;
   logic [CHUNK_W-1:0]         chunk;
   logic [PROD_W-1:0]          product;
   logic signed [ACC_W:0]      mag_signed;
   logic signed [ACC_W:0]      prod_signed;
   logic signed [ACC_W:0]      prod_shifted;

   always_comb begin
      abs_a        = op_a[VALUE_W-1] ? VALUE_W'(-op_a) : VALUE_W'(op_a);
      abs_b        = op_b[VALUE_W-1] ? VALUE_W'(-op_b) : VALUE_W'(op_b);
      chunk        = b_mag_ff[PAD_W-1 -: CHUNK_W];
      product      = {{CHUNK_W{1'b0}}, a_mag_ff} * {{MAG_W{1'b0}}, chunk};
      mag_signed   = $signed({1'b0, acc_ff});
      prod_signed  = neg_ff ? -mag_signed : mag_signed;
      prod_shifted = prod_signed >>> FRAC_W;

      state_in  = state_ff;
      a_mag_in  = a_mag_ff;
      b_mag_in  = b_mag_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;

      case (state_ff)
         M_IDLE: begin
            if (start) begin
               a_mag_in = abs_a[MAG_W-1:0];
               b_mag_in = PAD_W'(abs_b[MAG_W-1:0]);
               neg_in   = op_a[VALUE_W-1] ^ op_b[VALUE_W-1];
               acc_in   = '0;
               cnt_in   = CNT_W'(NUM_CHUNKS);
               state_in = M_ACCUM;
            end
         end
         M_ACCUM: begin
            acc_in   = (acc_ff << CHUNK_W) + ACC_W'(product);
            b_mag_in = b_mag_ff << CHUNK_W;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = M_ROUND;
            end
         end
         M_ROUND: begin
            result_in = prod_shifted[VALUE_W-1:0];
            done_in   = 1'b1;
            state_in  = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_mag_ff  <= a_mag_in;
      b_mag_ff  <= b_mag_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* rtl/core/met_div.sv */
`timescale 1ns / 1ps
// Palette index unit: floor(count * PALETTE_ENTRIES / limit), one quotient bit per
// cycle by restoring division, then clamped to the palette. Uses met_pkg.

module met_div #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [met_pkg::LIMIT_W-1:0]         count,
   input  logic [met_pkg::LIMIT_W-1:0]         limit,
   output logic                                done,
   output logic [met_pkg::PALETTE_INDEX_W-1:0] index
);
   import met_pkg::*;

   localparam int QUO_W     = $clog2(PALETTE_ENTRIES + 1);
   localparam int NUM_W     = LIMIT_W + QUO_W;
   localparam int CNT_W     = $clog2(QUO_W + 1);
   localparam int INDEX_TOP = (PALETTE_ENTRIES - 1 < PALETTE_MAX) ?
                              PALETTE_ENTRIES - 1 : PALETTE_MAX;

   typedef enum logic [1:0] {
      D_IDLE,
      D_STEP,
      D_CLAMP
   } div_state_type;

   div_state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]           rem_ff, rem_in;
   logic [LIMIT_W-1:0]           divisor_ff, divisor_in;
   logic [QUO_W-1:0]             low_ff, low_in;
   logic [QUO_W-1:0]             quo_ff, quo_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [PALETTE_INDEX_W-1:0]   index_ff, index_in;

   logic [NUM_W-1:0]             numerator;
   logic [LIMIT_W:0]             trial;
   logic [LIMIT_W:0]             diff;
   logic                         fits;

   always_comb begin
      numerator = NUM_W'(count) * NUM_W'(PALETTE_ENTRIES);
      trial     = {rem_ff, low_ff[QUO_W-1]};
      diff      = trial - {1'b0, divisor_ff};
      fits      = trial >= {1'b0, divisor_ff};

      state_in   = state_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      index_in   = index_ff;

      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in     = numerator[NUM_W-1:QUO_W];
               low_in     = numerator[QUO_W-1:0];
               divisor_in = limit;
               quo_in     = '0;
               cnt_in     = CNT_W'(QUO_W);
               state_in   = D_STEP;
            end
         end
         D_STEP: begin
            rem_in = fits ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
            low_in = low_ff << 1;
            quo_in = {quo_ff[QUO_W-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = D_CLAMP;
            end
         end
         D_CLAMP: begin
            index_in = (quo_ff > QUO_W'(INDEX_TOP)) ?
                       PALETTE_INDEX_W'(INDEX_TOP) : PALETTE_INDEX_W'(quo_ff);
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      index_ff   <= index_in;
   end

   assign done  = done_ff;
   assign index = index_ff;

endmodule

/* rtl/core/mandelbrot_escape_time_top.sv */
`timescale 1ns / 1ps
// Top level of the escape-time point evaluator: sequencer, orbit registers and
// result register. Instantiates met_mul and met_div; uses met_pkg.

// Each point c is iterated as z = z*z + c from z = 0 until |z| exceeds the escape
// radius of 4 or max_iterations steps have run. All products go through one shared
// multiplier, which works through ceil((FRACTION_BITS + 3) / 32) slices of 32 bits;
// an iteration uses three products plus one decision state, since the box test
// shares its state with the start of the second product. An escaped point then
// goes through the palette divider. One point is in flight at a time, and the next
// one is accepted while the previous result waits in the output register.

module mandelbrot_escape_time_top #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int FRACTION_BITS   = 28
) (
   input  logic                           clock,
   input  logic                           reset,
   // point_real [31:0], point_imag [63:32]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [met_pkg::REQ_DATA_W-1:0] req_tdata,
   // escaped [0], step_count [12:1], palette_index [20:13], zero fill [23:21]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [met_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [met_pkg::LIMIT_W-1:0]    csr_wdata
);
   import met_pkg::*;

   localparam int WIDE_W  = (FRACTION_BITS + 4 > POINT_W - 1) ? FRACTION_BITS + 4 : POINT_W - 1;
   localparam int Z_W     = WIDE_W + 2;
   localparam int MAG_W   = FRACTION_BITS + 3;

   localparam logic signed [Z_W-1:0] BOUND     = Z_W'(64'd4 << FRACTION_BITS);
   localparam logic signed [Z_W-1:0] NEG_BOUND = -BOUND;
   localparam logic signed [Z_W:0]   RADIUS_SQ = (Z_W + 1)'(64'd16 << FRACTION_BITS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_XY,
      S_WAIT_XY,
      S_CHECK,
      S_WAIT_XX,
      S_MUL_YY,
      S_WAIT_YY,
      S_SUM,
      S_DIV,
      S_WAIT_DIV,
      S_FINISH
   } seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]           limit_ff, limit_in;
   logic signed [Z_W-1:0]        cr_ff, cr_in;
   logic signed [Z_W-1:0]        ci_ff, ci_in;
   logic signed [Z_W-1:0]        x_ff, x_in;
   logic signed [Z_W-1:0]        y_ff, y_in;
   logic signed [Z_W-1:0]        sqx_ff, sqx_in;
   logic signed [Z_W-1:0]        sqy_ff, sqy_in;
   logic [LIMIT_W-1:0]           count_ff, count_in;
   logic                         esc_ff, esc_in;
   logic [PALETTE_INDEX_W-1:0]   idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   result_type                   rsp_ff, rsp_in;

   logic                         mul_start;
   logic signed [Z_W-1:0]        mul_a;
   logic signed [Z_W-1:0]        mul_b;
   logic                         mul_done;
   logic signed [Z_W-1:0]        mul_result;
   logic                         div_start;
   logic                         div_done;
   logic [PALETTE_INDEX_W-1:0]   div_index;

   logic signed [Z_W:0]          sq_sum;
   logic                         out_of_box;

   met_mul #(
      .VALUE_W (Z_W),
      .MAG_W   (MAG_W),
      .FRAC_W  (FRACTION_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   met_div #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .count (count_ff),
      .limit (limit_ff),
      .done  (div_done),
      .index (div_index)
   );

   always_comb begin
      sq_sum     = {sqx_ff[Z_W-1], sqx_ff} + {sqy_ff[Z_W-1], sqy_ff};
      out_of_box = (x_ff > BOUND) || (x_ff < NEG_BOUND) ||
                   (y_ff > BOUND) || (y_ff < NEG_BOUND);

      state_in     = state_ff;
      limit_in     = csr_valid ? csr_wdata : limit_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      count_in     = count_ff;
      esc_in       = esc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      mul_start    = 1'b0;
      mul_a        = x_ff;
      mul_b        = y_ff;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cr_in    = {{(Z_W - POINT_W){req_tdata[POINT_W-1]}}, req_tdata[POINT_W-1:0]};
               ci_in    = {{(Z_W - POINT_W){req_tdata[REQ_DATA_W-1]}},
                           req_tdata[REQ_DATA_W-1:POINT_W]};
               x_in     = '0;
               y_in     = '0;
               sqx_in   = '0;
               sqy_in   = '0;
               count_in = '0;
               esc_in   = 1'b0;
               idx_in   = '0;
               state_in = (limit_ff == '0) ? S_FINISH : S_MUL_XY;
            end
         end
         S_MUL_XY: begin
            mul_start = 1'b1;
            state_in  = S_WAIT_XY;
         end
         S_WAIT_XY: begin
            if (mul_done) begin
               x_in     = sqx_ff - sqy_ff + cr_ff;
               y_in     = (mul_result <<< 1) + ci_ff;
               count_in = count_ff + LIMIT_W'(1);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (out_of_box) begin
               esc_in   = 1'b1;
               state_in = S_DIV;
            end else begin
               mul_start = 1'b1;
               mul_b     = x_ff;
               state_in  = S_WAIT_XX;
            end
         end
         S_WAIT_XX: begin
            if (mul_done) begin
               sqx_in   = mul_result;
               state_in = S_MUL_YY;
            end
         end
         S_MUL_YY: begin
            mul_start = 1'b1;
            mul_a     = y_ff;
            state_in  = S_WAIT_YY;
         end
         S_WAIT_YY: begin
            if (mul_done) begin
               sqy_in   = mul_result;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sq_sum > RADIUS_SQ) begin
               esc_in   = 1'b1;
               state_in = S_DIV;
            end else if (count_ff == limit_ff) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_MUL_XY;
            end
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_WAIT_DIV;
         end
         S_WAIT_DIV: begin
            if (div_done) begin
               idx_in   = div_index;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.escaped       = esc_ff;
               rsp_in.step_count    = count_ff;
               rsp_in.palette_index = idx_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      count_ff <= count_in;
      esc_ff   <= esc_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RESULT_W){1'b0}}, rsp_ff};

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_WAIT_XY || state_ff == S_WAIT_XX ||
                    state_ff == S_WAIT_YY))
      else $error("Multiplier finished while the sequencer was not waiting for it.");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_WAIT_DIV)
      else $error("Divider finished while the sequencer was not waiting for it.");

   a_inside_is_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.escaped |-> rsp_ff.palette_index == '0)
      else $error("A point inside the set carries a nonzero palette index.");

   a_escape_has_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.escaped |-> rsp_ff.step_count != '0)
      else $error("An escaped point reports zero iterations.");

endmodule
